### sv/rpv_pkg.sv
// Shared types and constants for the request path validator.
// Used by rpv_step and request_path_validator; no dependencies.
package rpv_pkg;

    localparam int unsigned CountWidth = 17;
    localparam int unsigned MaxLenWidth = 16;

    localparam logic [7:0] CharSlash = 8'h2F;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharNul   = 8'h00;

    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContBits  = 8'h80;
    localparam logic [2:0] Lead2Code = 3'b110;
    localparam logic [3:0] Lead3Code = 4'b1110;
    localparam logic [4:0] Lead4Code = 5'b11110;

    localparam logic [MaxLenWidth-1:0] MaxLenReset = 16'd1024;
    localparam logic [1:0]             SegLenCap   = 2'd3;

    typedef struct packed {
        logic [CountWidth-1:0] byte_count;
        logic [1:0]            segment_length;
        logic                  last_was_dot;
        logic                  second_last_was_dot;
        logic [1:0]            continuations_due;
        logic                  failed;
    } path_state_t;

    localparam path_state_t PathStateClear = '0;

endpackage

### sv/rpv_step.sv
// Per-byte next-state and verdict logic of the request path validator.
// Depends on rpv_pkg for the path state type and character constants.
module rpv_step
    import rpv_pkg::*;
(
    input  path_state_t            cur_state,
    input  logic [7:0]             path_byte,
    input  logic                   last_byte,
    input  logic [MaxLenWidth-1:0] max_length,
    output path_state_t            next_state,
    output logic                   path_ok
);

    logic        first;
    logic        is_slash;
    logic        old_dot_seg;
    logic        new_dot_seg;
    logic        fail;
    logic        fail_end;
    path_state_t upd;

    assign first    = (cur_state.byte_count == '0);
    assign is_slash = (path_byte == CharSlash);

    assign old_dot_seg = ((cur_state.segment_length == 2'd1) && cur_state.last_was_dot) ||
                         ((cur_state.segment_length == 2'd2) && cur_state.last_was_dot &&
                          cur_state.second_last_was_dot);

    always_comb begin
        upd  = cur_state;
        fail = cur_state.failed;

        if (first) begin
            if (!is_slash) fail = 1'b1;
            upd.segment_length = 2'd0;
        end else if (is_slash) begin
            if ((cur_state.segment_length == 2'd0) || old_dot_seg) fail = 1'b1;
            upd.segment_length = 2'd0;
            if (last_byte) fail = 1'b1;
        end else begin
            if (path_byte == CharNul) fail = 1'b1;
            if (cur_state.segment_length != SegLenCap) begin
                upd.segment_length = cur_state.segment_length + 2'd1;
            end
        end
        upd.second_last_was_dot = cur_state.last_was_dot;
        upd.last_was_dot        = (path_byte == CharDot);

        if (cur_state.continuations_due != 2'd0) begin
            if ((path_byte & ContMask) != ContBits) fail = 1'b1;
            upd.continuations_due = cur_state.continuations_due - 2'd1;
        end else if (!path_byte[7]) begin
            upd.continuations_due = 2'd0;
        end else if (path_byte[7:5] == Lead2Code) begin
            upd.continuations_due = 2'd1;
        end else if (path_byte[7:4] == Lead3Code) begin
            upd.continuations_due = 2'd2;
        end else if (path_byte[7:3] == Lead4Code) begin
            upd.continuations_due = 2'd3;
        end else begin
            fail = 1'b1;
        end

        if (!cur_state.byte_count[CountWidth-1]) begin
            upd.byte_count = cur_state.byte_count + {{(CountWidth-1){1'b0}}, 1'b1};
        end
        upd.failed = fail;
    end

    assign new_dot_seg = ((upd.segment_length == 2'd1) && upd.last_was_dot) ||
                         ((upd.segment_length == 2'd2) && upd.last_was_dot &&
                          upd.second_last_was_dot);

    always_comb begin
        fail_end = upd.failed;
        if (!first && !is_slash && new_dot_seg) fail_end = 1'b1;
        if (upd.continuations_due != 2'd0) fail_end = 1'b1;
        if (upd.byte_count > {1'b0, max_length}) fail_end = 1'b1;
    end

    assign path_ok    = !fail_end;
    assign next_state = last_byte ? PathStateClear : upd;

endmodule

### sv/request_path_validator.sv
// Request path validator: checks path syntax and UTF-8 shape one byte per cycle.
// The verdict appears on m_ in the cycle after the final byte is accepted.
// Throughput: one byte per cycle; the output register stalls input only while a
// verdict waits on m_ready. Reset (synchronous, aresetn low) clears path state,
// drops any pending verdict and sets max_length to 1024. Depends on rpv_pkg, rpv_step.
module request_path_validator
    import rpv_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MaxLenWidth-1:0] cfg_max_length,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_path_byte,
    input  logic                   s_last_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_path_ok
);

    path_state_t            state_reg;
    path_state_t            state_next;
    logic [MaxLenWidth-1:0] max_length_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   m_path_ok_reg;
    logic                   path_ok;
    logic                   s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    rpv_step u_step (
        .cur_state  (state_reg),
        .path_byte  (s_path_byte),
        .last_byte  (s_last_byte),
        .max_length (max_length_reg),
        .next_state (state_next),
        .path_ok    (path_ok)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire && s_last_byte) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= PathStateClear;
            max_length_reg <= MaxLenReset;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) state_reg <= state_next;
            if (cfg_valid) max_length_reg <= cfg_max_length;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_last_byte) m_path_ok_reg <= path_ok;
    end

    assign m_valid   = m_valid_reg;
    assign m_path_ok = m_path_ok_reg;

endmodule

### tb/tb_top.sv
// Testbench for request_path_validator: streams request paths byte by byte and checks
// each verdict against a predictor kept in step with every accepted byte.
// Depends on rpv_pkg and request_path_validator.
module tb_top;
    import rpv_pkg::*;

    typedef logic [7:0] path_bytes_t[$];

    typedef struct {
        logic [7:0] path_byte;
        logic       last_byte;
    } path_req_t;

    localparam logic [CountWidth-1:0] CountCap = 17'h10000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [MaxLenWidth-1:0] cfg_max_length = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_path_byte = '0;
    logic                   s_last_byte = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_path_ok;

    path_req_t              path_req_q[$];
    logic                   verdict_q[$];
    int unsigned            reqs_in_flight = 0;
    int unsigned            send_idle_pct = 36;
    int unsigned            recv_idle_pct = 36;
    int unsigned            errors = 0;

    logic [MaxLenWidth-1:0] max_len_cfg = MaxLenReset;
    logic [CountWidth-1:0]  path_len;
    logic [1:0]             seg_len;
    logic                   prev_dot;
    logic                   prev2_dot;
    logic [1:0]             cont_left;
    logic                   path_bad;

    request_path_validator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_max_length (cfg_max_length),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_path_byte    (s_path_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_path_ok      (m_path_ok)
    );

    always #6 aclk = ~aclk;

    function automatic logic in_dot_segment();
        return (seg_len == 2'd1 && prev_dot) || (seg_len == 2'd2 && prev_dot && prev2_dot);
    endfunction

    task automatic clear_path_state();
        path_len = '0;
        seg_len = '0;
        prev_dot = 1'b0;
        prev2_dot = 1'b0;
        cont_left = '0;
        path_bad = 1'b0;
    endtask

    task automatic predict_verdict(input logic [7:0] b, input logic last);
        logic first_b;
        first_b = (path_len == '0);
        if (first_b) begin
            if (b != CharSlash) path_bad = 1'b1;
            seg_len = '0;
        end else if (b == CharSlash) begin
            if (seg_len == '0 || in_dot_segment()) path_bad = 1'b1;
            seg_len = '0;
            if (last) path_bad = 1'b1;
        end else begin
            if (b == CharNul) path_bad = 1'b1;
            if (seg_len < SegLenCap) seg_len++;
        end
        prev2_dot = prev_dot;
        prev_dot = (b == CharDot);

        if (cont_left != '0) begin
            if ((b & ContMask) != ContBits) path_bad = 1'b1;
            cont_left--;
        end else if (b[7] == 1'b0) begin
            cont_left = '0;
        end else if (b[7:5] == Lead2Code) begin
            cont_left = 2'd1;
        end else if (b[7:4] == Lead3Code) begin
            cont_left = 2'd2;
        end else if (b[7:3] == Lead4Code) begin
            cont_left = 2'd3;
        end else begin
            path_bad = 1'b1;
        end

        if (path_len < CountCap) path_len++;

        if (last) begin
            if (!first_b && b != CharSlash && in_dot_segment()) path_bad = 1'b1;
            if (cont_left != '0) path_bad = 1'b1;
            if (path_len > {1'b0, max_len_cfg}) path_bad = 1'b1;
            verdict_q.push_back(!path_bad);
            clear_path_state();
        end
    endtask

    initial clear_path_state();

    // request driver
    always @(posedge aclk) begin : drive
        path_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_verdict(s_path_byte, s_last_byte);
                reqs_in_flight--;
            end
            if (!s_valid || s_ready) begin
                if (path_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = path_req_q.pop_front();
                    s_valid <= 1'b1;
                    s_path_byte <= req.path_byte;
                    s_last_byte <= req.last_byte;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // verdict monitor
    always @(posedge aclk) begin : watch
        logic want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, got path_ok=%0b",
                             $time, m_path_ok);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_path_ok !== want) begin
                        $display("%0t: path_ok mismatch, expected %0b, got %0b",
                                 $time, want, m_path_ok);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic queue_path(input path_bytes_t p);
        for (int i = 0; i < p.size(); i++) begin
            path_req_q.push_back('{path_byte: p[i], last_byte: (i == p.size() - 1)});
            reqs_in_flight++;
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (reqs_in_flight != 0 || verdict_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_max_length(input logic [MaxLenWidth-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_max_length <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len_cfg = v;
    endtask

    task automatic push_seg_char(inout path_bytes_t p);
        int unsigned pick;
        int unsigned n_cont;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            p.push_back(CharDot);
        end else if (pick < 85) begin
            do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CharSlash || c == CharDot);
            p.push_back(c);
        end else begin
            n_cont = $urandom_range(1, 3);
            c = 8'($urandom_range(0, 255));
            case (n_cont)
                1: p.push_back({Lead2Code, c[4:0]});
                2: p.push_back({Lead3Code, c[3:0]});
                default: p.push_back({Lead4Code, c[2:0]});
            endcase
            repeat (n_cont) begin
                c = 8'($urandom_range(0, 255));
                p.push_back(ContBits | (c & ~ContMask));
            end
        end
    endtask

    task automatic make_random_path(output path_bytes_t p);
        int unsigned mode;
        int unsigned n_seg;
        int unsigned len;
        p = {};
        mode = $urandom_range(0, 99);
        if (mode < 15) begin
            len = $urandom_range(1, 8);
            repeat (len) p.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) p[0] = CharSlash;
        end else if (mode < 20) begin
            p.push_back(CharSlash);
        end else begin
            n_seg = $urandom_range(1, 4);
            repeat (n_seg) begin
                p.push_back(CharSlash);
                len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
                repeat (len) push_seg_char(p);
            end
            // break a well-formed path now and then
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0: p.push_back(CharSlash);
                    1: p.insert($urandom_range(1, p.size()), CharNul);
                    2: if (p.size() > 1) p.delete(p.size() - 1);
                    3: p[$urandom_range(0, p.size() - 1)] = 8'($urandom_range(0, 255));
                    default: if (p.size() > 1) p.delete(0);
                endcase
            end
        end
    endtask

    task automatic run_random_phase(input logic [MaxLenWidth-1:0] max_len,
                                    input int unsigned idle_pct,
                                    input int unsigned min_bytes);
        path_bytes_t p;
        int unsigned sent;
        wait_drained();
        set_max_length(max_len);
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        @(negedge aclk);
        sent = 0;
        while (sent < min_bytes) begin
            make_random_path(p);
            queue_path(p);
            sent += p.size();
        end
    endtask

    task automatic queue_long_path(input int unsigned n);
        path_bytes_t p;
        p = {};
        p.push_back(CharSlash);
        repeat (n - 1) p.push_back(8'h61);
        queue_path(p);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        queue_path('{CharSlash});
        queue_path('{8'h61});
        queue_path('{CharSlash, 8'h61, CharSlash});
        queue_path('{CharSlash, CharSlash});
        queue_path('{CharSlash, CharDot});
        queue_path('{CharSlash, CharDot, CharDot});
        queue_path('{CharSlash, CharDot, CharDot, CharDot});
        queue_path('{CharSlash, 8'h61, CharNul});
        queue_path('{CharSlash, 8'hC3, 8'hA9});
        queue_path('{CharSlash, 8'hE2, 8'h82});
        queue_path('{CharSlash, 8'hF0, 8'h9F, 8'h98, 8'h80});
        queue_path('{CharSlash, 8'hFF});

        run_random_phase(16'd0, 36, 40);
        run_random_phase(16'd1, 36, 40);

        // length boundary, no idling
        run_random_phase(16'd40, 0, 80);
        queue_long_path(40);
        queue_long_path(41);

        run_random_phase(16'd4, 36, 60);
        run_random_phase(16'd12, 36, 60);
        run_random_phase(16'($urandom_range(2, 40)), 36, 60);
        run_random_phase(MaxLenReset, 36, 60);
        run_random_phase(16'd30, 36, 60);
        run_random_phase(16'hFFFF, 36, 60);
        wait_drained();

        if (errors == 0) begin
            $display("request_path_validator verification clean");
        end else begin
            $display("request_path_validator verification failed");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("request_path_validator verification failed");
        $finish;
    end

endmodule
